@@ src/bmprle_pkg.sv @@
// ============================================================================
// bmprle_pkg : shared types and constants of the BMP RLE run decoder
// Beat types, parse phases, controller/datapath command and status bundles.
// ============================================================================
`default_nettype none

package bmprle_pkg;

  // Largest supported image size in pixels
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Field and internal widths
  localparam int DIM_W     = 13;          // configured width / height
  localparam int COL_W     = 12;          // column, always below the width
  localparam int RUN_W     = 25;          // run length and pixel position
  localparam int MOD_W     = 26;          // remainder unit dividend, even
  localparam int DY_W      = 8 + DIM_W;   // dy times width
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  // Escape codes that follow a zero count byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic [7:0] NIBBLE_MASK = 8'b0000_1111;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } bmprle_in_t;

  typedef struct packed {
    logic [7:0]       first_index;
    logic [7:0]       second_index;
    logic [RUN_W-1:0] run_length;
    logic             image_done;
    logic             overrun;
  } bmprle_out_t;

  // Byte parser phase
  typedef enum logic [6:0] {
    PH_COUNT  = 7'b0000001,
    PH_SECOND = 7'b0000010,
    PH_DX     = 7'b0000100,
    PH_DY     = 7'b0001000,
    PH_ABS    = 7'b0010000,
    PH_PAD    = 7'b0100000,
    PH_DONE   = 7'b1000000
  } bmprle_phase_t;

  // Controller to datapath
  typedef struct packed {
    logic in_load;      // capture the accepted beat
    logic mod_start;    // start a remainder pass
    logic mod_src_run;  // dividend is column plus run length, else column
    logic col_load;     // take the remainder as the new column
    logic decode;       // parse the byte and build the run
    logic out_load;     // move the run into the output register
  } bmprle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mod_done;
    logic run_valid;
    logic last;
    logic out_free;
  } bmprle_status_t;

endpackage

`default_nettype wire

@@ src/bmprle_mod.sv @@
// ============================================================================
// bmprle_mod : iterative remainder unit
// Restoring remainder by the image width, two dividend bits per cycle,
// with a short path, done in the cycle after start, when the dividend is already below the width.
// ============================================================================
`default_nettype none

module bmprle_mod
  import bmprle_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MOD_W-1:0] dividend,
  input  logic [DIM_W-1:0] divisor,
  output logic             done,
  output logic [COL_W-1:0] remainder
);

  localparam int STEPS = MOD_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [MOD_W-1:0] shreg;
  logic [DIM_W-1:0] rem;

  logic [DIM_W:0] r1_raw, r1, r2_raw, r2;
  logic [DIM_W:0] div_ext;

  assign div_ext = {1'b0, divisor};

  // Two restoring steps per cycle
  always_comb begin
    r1_raw = {rem, shreg[MOD_W-1]};
    r1     = (r1_raw >= div_ext) ? (r1_raw - div_ext) : r1_raw;
    r2_raw = {r1[DIM_W-1:0], shreg[MOD_W-2]};
    r2     = (r2_raw >= div_ext) ? (r2_raw - div_ext) : r2_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // Pulse done on the short path or on the last iteration
      done <= start ? (dividend < MOD_W'(divisor)) : (busy && cnt == '0);
      if (start) begin
        if (dividend < MOD_W'(divisor)) begin
          rem  <= dividend[DIM_W-1:0];
        end else begin
          busy  <= 1'b1;
          shreg <= dividend;
          rem   <= '0;
          cnt   <= CNT_W'(STEPS - 1);
        end
      end else if (busy) begin
        rem   <= r2[DIM_W-1:0];
        shreg <= {shreg[MOD_W-3:0], 2'b00};
        cnt   <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign remainder = rem[COL_W-1:0];

endmodule

`default_nettype wire

@@ src/bmprle_datapath.sv @@
// ============================================================================
// bmprle_datapath : configuration, parser state, run builder, output register
// Parses one byte per decode command, clamps the run to the image and keeps
// the pixel position and column.
// ============================================================================
`default_nettype none

module bmprle_datapath
  import bmprle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  input  bmprle_in_t           in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output bmprle_out_t          out_data,
  input  bmprle_cmd_t          cmd,
  output bmprle_status_t       status
);

  // Configuration
  logic             rle4;
  logic [DIM_W-1:0] width_cfg, height_cfg;
  logic [DIM_W-1:0] eff_w, eff_h;

  // Captured beat and products
  logic [7:0]       byte_q;
  logic             last_q;
  logic [RUN_W-1:0] total;
  logic [DY_W-1:0]  dy_prod;
  logic [2*DIM_W-1:0] area;

  // Parser state
  bmprle_phase_t    phase, phase_next;
  logic [7:0]       held_count, held_count_next;
  logic [7:0]       held_dx, held_dx_next;
  logic [7:0]       abs_left, abs_left_next;
  logic             pad_pending, pad_next;
  logic [RUN_W-1:0] pos;
  logic [COL_W-1:0] column;

  // Run built by the last decode
  logic             run_valid;
  logic [7:0]       run_a, run_b;
  logic [RUN_W-1:0] run_len;
  logic             run_end, run_over;

  // Decode logic
  logic [7:0]       idx_a, idx_b;
  logic [8:0]       byte_inc;
  logic             abs_pad;
  logic [7:0]       abs_step;
  logic             req_valid, end_bm;
  logic [RUN_W-1:0] req_len, left, clamp_len, pos_sum;
  logic             over;
  logic             run_ok;
  logic             run_pix;

  // Remainder unit
  logic [MOD_W-1:0] mod_dividend;
  logic             mod_done;
  logic [COL_W-1:0] mod_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      rle4       <= 1'b0;
      width_cfg  <= DIM_W'(1);
      height_cfg <= DIM_W'(1);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_RLE_MODE:     rle4       <= cfg_wdata[0];
        CFG_IMAGE_WIDTH:  width_cfg  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: height_cfg <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Zero reads as one, oversize saturates
  assign eff_w = (width_cfg == '0) ? DIM_W'(1) :
                 (width_cfg > MAX_W_DIM) ? MAX_W_DIM : width_cfg;
  assign eff_h = (height_cfg == '0) ? DIM_W'(1) :
                 (height_cfg > MAX_H_DIM) ? MAX_H_DIM : height_cfg;
  assign area  = eff_w * eff_h;

  // Products track the registers every cycle; both settle before decode
  always_ff @(posedge clk) begin
    total   <= area[RUN_W-1:0];
    dy_prod <= {{DIM_W{1'b0}}, byte_q} * {8'b0, eff_w};
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      byte_q <= in_data.data_byte;
      last_q <= in_data.last_byte;
    end
  end

  assign idx_a    = rle4 ? {4'b0000, byte_q[7:4]} : byte_q;
  assign idx_b    = rle4 ? (byte_q & NIBBLE_MASK) : byte_q;
  assign byte_inc = {1'b0, byte_q} + 9'd1;
  // Literal byte count odd: pad byte follows
  assign abs_pad  = rle4 ? byte_inc[1] : byte_q[0];
  assign abs_step = (rle4 && abs_left >= 8'd2) ? 8'd2 : 8'd1;
  assign left     = (pos < total) ? (total - pos) : '0;
  // Encoded runs and literals carry the byte; escape fills carry index zero
  assign run_pix  = (phase == PH_ABS) || (phase == PH_SECOND && held_count != 8'd0);

  always_comb begin
    phase_next      = phase;
    held_count_next = held_count;
    held_dx_next    = held_dx;
    abs_left_next   = abs_left;
    pad_next        = pad_pending;
    req_valid       = 1'b0;
    req_len         = '0;
    end_bm          = 1'b0;
    unique case (phase)
      PH_COUNT: begin
        held_count_next = byte_q;
        phase_next      = PH_SECOND;
      end
      PH_SECOND: begin
        phase_next = PH_COUNT;
        if (held_count != 8'd0) begin
          req_valid = 1'b1;
          req_len   = RUN_W'(held_count);
        end else begin
          unique case (byte_q)
            ESC_EOL: begin
              if (column != '0) begin
                req_valid = 1'b1;
                req_len   = RUN_W'(eff_w - {1'b0, column});
              end
            end
            ESC_EOB: begin
              req_valid  = 1'b1;
              req_len    = left;
              end_bm     = 1'b1;
              phase_next = PH_DONE;
            end
            ESC_DELTA: phase_next = PH_DX;
            default: begin
              abs_left_next = byte_q;
              pad_next      = abs_pad;
              phase_next    = PH_ABS;
            end
          endcase
        end
      end
      PH_DX: begin
        held_dx_next = byte_q;
        phase_next   = PH_DY;
      end
      PH_DY: begin
        phase_next = PH_COUNT;
        req_valid  = 1'b1;
        req_len    = RUN_W'(dy_prod) + RUN_W'(held_dx);
      end
      PH_ABS: begin
        req_valid     = 1'b1;
        req_len       = RUN_W'(abs_step);
        abs_left_next = abs_left - abs_step;
        if (abs_left_next == 8'd0) begin
          phase_next = pad_pending ? PH_PAD : PH_COUNT;
          pad_next   = 1'b0;
        end
      end
      PH_PAD:  phase_next = PH_COUNT;
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_COUNT;
    endcase
  end

  // Clamp to the pixels left in the image
  assign over      = req_len > left;
  assign clamp_len = over ? left : req_len;
  assign run_ok    = req_valid && (clamp_len != '0);
  assign pos_sum   = pos + clamp_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_COUNT;
      held_count  <= '0;
      held_dx     <= '0;
      abs_left    <= '0;
      pad_pending <= 1'b0;
      pos         <= '0;
      column      <= '0;
      run_valid   <= 1'b0;
    end else begin
      if (cmd.decode) begin
        run_valid <= run_ok;
        run_a     <= run_pix ? idx_a : 8'd0;
        run_b     <= run_pix ? idx_b : 8'd0;
        run_len   <= clamp_len;
        run_over  <= over;
        run_end   <= end_bm || (pos_sum >= total);
        if (last_q) begin
          // Stream end: drop partial pairs, restart at the first pixel
          phase       <= PH_COUNT;
          held_count  <= '0;
          held_dx     <= '0;
          abs_left    <= '0;
          pad_pending <= 1'b0;
          pos         <= '0;
          column      <= '0;
        end else begin
          phase       <= phase_next;
          held_count  <= held_count_next;
          held_dx     <= held_dx_next;
          abs_left    <= abs_left_next;
          pad_pending <= pad_next;
          if (run_ok) begin
            pos <= pos_sum;
          end
        end
      end else if (cmd.col_load) begin
        column <= mod_rem;
      end
    end
  end

  assign mod_dividend = cmd.mod_src_run ? (MOD_W'(column) + MOD_W'(run_len))
                                        : MOD_W'(column);

  bmprle_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.mod_start),
    .dividend  (mod_dividend),
    .divisor   (eff_w),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.first_index  <= run_a;
      out_data.second_index <= run_b;
      out_data.run_length   <= run_len;
      out_data.image_done   <= run_end;
      out_data.overrun      <= run_over;
    end
  end

  assign status.mod_done  = mod_done;
  assign status.run_valid = run_valid;
  assign status.last      = last_q;
  assign status.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ src/bmprle_ctrl.sv @@
// ============================================================================
// bmprle_ctrl : sequencing state machine
// Steps each beat through column reduction and decode, then, when a run is
// produced, through result hand-off and, but for the last byte, column update.
// ============================================================================
`default_nettype none

module bmprle_ctrl
  import bmprle_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bmprle_status_t status,
  output bmprle_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RED    = 6'b000010,
    S_RWAIT  = 6'b000100,
    S_DECODE = 6'b001000,
    S_EMIT   = 6'b010000,
    S_CWAIT  = 6'b100000
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_RED;
        end
      end
      S_RED: begin
        // Bring the column below the current width
        cmd.mod_start = 1'b1;
        state_next    = S_RWAIT;
      end
      S_RWAIT: begin
        if (status.mod_done) begin
          cmd.col_load = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!status.run_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.mod_start   = 1'b1;
            cmd.mod_src_run = 1'b1;
            state_next      = S_CWAIT;
          end
        end
      end
      S_CWAIT: begin
        if (status.mod_done) begin
          cmd.col_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

`default_nettype wire

@@ src/bmp_rle_run_decoder_core.sv @@
// ============================================================================
// bmp_rle_run_decoder_core : BMP RLE8 / RLE4 run decoder
// Turns a compressed pixel byte stream into run beats: two alternating
// palette indices, a pixel count, image-done and overrun flags.
// ============================================================================
//
//   channel   direction  handshake            payload
//   --------  ---------  -------------------  ----------------------------------
//   in        sink       in_valid / in_ready  in_data  (data_byte, last_byte)
//   out       source     out_valid/out_ready  out_data (indices, run, flags)
//   cfg       sink       cfg_write_en only    cfg_index, cfg_wdata
//
// Sequence: the controller walks column reduction, decode, hand-off and
// column update one step at a time, skipping hand-off and column update
// when a beat gives no run.  The two column passes share one remainder
// unit; a pass whose dividend is not already below the width takes two
// dividend bits per cycle over 26 bits.
// Reset: synchronous; parser back to the count byte, position and column
// zero, width and height one, RLE8 mode, output empty.
// Stalls: a finished run waits in the output register while the next beat
// is taken; the controller holds only when a new run finds it still full.
// ============================================================================
`default_nettype none

module bmp_rle_run_decoder_core
  import bmprle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration writes
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  // Byte stream
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bmprle_in_t           in_data,
  // Run stream
  output logic                 out_valid,
  input  logic                 out_ready,
  output bmprle_out_t          out_data
);

  bmprle_cmd_t    cmd;
  bmprle_status_t status;

  // Sequencing: one beat at a time through the datapath
  bmprle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Parser, run clamp, position/column tracking and output register
  bmprle_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_data      (in_data),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

`default_nettype wire

@@ src/bmprle_checker.sv @@
// ============================================================================
// bmprle_checker : port-level checks of the run decoder
// Watches the top-level ports only; bound onto the core below.
// ============================================================================
`default_nettype none

module bmprle_checker
  import bmprle_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input bmprle_out_t          out_data
);

  // A stalled run beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("run beat changed while stalled");

  // Empty runs are never sent
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.run_length != '0)
    else $error("zero-length run beat");

  // A clamped run always lands on the last pixel of the image
  a_over_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overrun |-> out_data.image_done)
    else $error("overrun without image done");

  // One byte at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("byte accepted on consecutive cycles");

endmodule

bind bmp_rle_run_decoder_core bmprle_checker u_checker (.*);

`default_nettype wire
